[rtl/erm_pkg.sv]
// Package for the Euler XYZ rotation matrix block: types, widths and sine table.
package erm_pkg;

  localparam int SINE_ENTRIES  = 4096;
  localparam int FRACTION_BITS = 12;

  localparam int ANGLE_W = $clog2(SINE_ENTRIES);
  localparam int QUARTER = SINE_ENTRIES / 4;
  localparam int HALF    = SINE_ENTRIES / 2;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;
  localparam int SIN_W   = FRACTION_BITS + 2;
  localparam int NEG_W   = SIN_W + 1;
  localparam int PROD_W  = 2 * NEG_W;
  localparam int SHF_W   = PROD_W - FRACTION_BITS;
  localparam int PROD2_W = SHF_W + NEG_W;
  localparam int SUM_W   = PROD2_W + 1;

  localparam real RAD_PER_STEP = 3.14159265358979323846 / (2.0 * real'(QUARTER));

  typedef logic signed [SIN_W-1:0] sine_t;
  typedef sine_t sine_tab_t [SINE_ENTRIES];

  typedef struct packed {
    logic [IN_W-1:0] angle_x;
    logic [IN_W-1:0] angle_y;
    logic [IN_W-1:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } erm_out_t;

  // round(2^F * sin(2*pi*i/N)), built from the first quarter wave
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    int        m;
    int        j;
    int        q;
    real       v;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      m = (i < HALF) ? i : i - HALF;
      j = (m <= QUARTER) ? m : HALF - m;
      v = $sin(RAD_PER_STEP * real'(j)) * real'(1 << FRACTION_BITS);
      q = $rtoi(v + 0.5);
      tab[i] = (i < HALF) ? SIN_W'(q) : -SIN_W'(q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[rtl/euler_rotation_matrix.sv]
// Euler XYZ rotation matrix Rx*Ry*Rz in fixed point, four-stage pipeline.
// A start transfer reaches out_valid through the stage valid bits v1_r to v4_r.
// Throughput: one angle triple per cycle; busy is always low.
// Stage 1 reads six sine/cosine ROM ports, stage 2 forms the first products,
// stage 3 the second products of the three-factor terms, stage 4 the sums.
// Synchronous active-low reset clears the stage valid bits only.
module euler_rotation_matrix
  import erm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  erm_in_t  in_data,
  output logic     out_valid,
  output erm_out_t out_data
);

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: table lookups
  logic [ANGLE_W-1:0] ax, ay, az;
  sine_t s1_sx_r, s1_sy_r, s1_sz_r, s1_cx_r, s1_cy_r, s1_cz_r;

  // stage 2: first products
  logic signed [NEG_W-1:0] sx, sy, sz, cx, cy, cz, nsx, nsy, nsz;
  logic signed [PROD_W-1:0] p_sxsy_r, p_cxnsy_r, p_cxsy_r, p_cycz_r, p_cynsz_r;
  logic signed [PROD_W-1:0] p_nsxcy_r, p_cxsz_r, p_cxcz_r, p_sxsz_r, p_sxcz_r;
  logic signed [PROD_W-1:0] p_cxcy_r;
  logic signed [NEG_W-1:0]  s2_sz_r, s2_nsz_r, s2_cz_r;
  sine_t                    s2_sy_r;

  // stage 3: second products
  logic signed [SHF_W-1:0]   h_sxsy, h_cxnsy, h_cxsy;
  logic signed [PROD2_W-1:0] q10_r, q11_r, q20_r, q21_r;
  logic signed [PROD_W-1:0]  s3_cxsz_r, s3_cxcz_r, s3_sxsz_r, s3_sxcz_r;
  logic signed [OUT_W-1:0]   s3_m00_r, s3_m01_r, s3_m02_r, s3_m12_r, s3_m22_r;

  // stage 4: sums
  logic signed [SUM_W-1:0] sum10, sum11, sum20, sum21;
  erm_out_t                out_r;

  assign busy = 1'b0;

  assign ax = in_data.angle_x[ANGLE_W-1:0];
  assign ay = in_data.angle_y[ANGLE_W-1:0];
  assign az = in_data.angle_z[ANGLE_W-1:0];

  assign sx  = NEG_W'(s1_sx_r);
  assign sy  = NEG_W'(s1_sy_r);
  assign sz  = NEG_W'(s1_sz_r);
  assign cx  = NEG_W'(s1_cx_r);
  assign cy  = NEG_W'(s1_cy_r);
  assign cz  = NEG_W'(s1_cz_r);
  assign nsx = -sx;
  assign nsy = -sy;
  assign nsz = -sz;

  assign h_sxsy  = SHF_W'(p_sxsy_r >>> FRACTION_BITS);
  assign h_cxnsy = SHF_W'(p_cxnsy_r >>> FRACTION_BITS);
  assign h_cxsy  = SHF_W'(p_cxsy_r >>> FRACTION_BITS);

  assign sum10 = SUM_W'(q10_r) + SUM_W'(s3_cxsz_r);
  assign sum11 = SUM_W'(q11_r) + SUM_W'(s3_cxcz_r);
  assign sum20 = SUM_W'(q20_r) + SUM_W'(s3_sxsz_r);
  assign sum21 = SUM_W'(q21_r) + SUM_W'(s3_sxcz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sx_r <= SINE_TAB[ax];
    s1_sy_r <= SINE_TAB[ay];
    s1_sz_r <= SINE_TAB[az];
    s1_cx_r <= SINE_TAB[ax + ANGLE_W'(QUARTER)];
    s1_cy_r <= SINE_TAB[ay + ANGLE_W'(QUARTER)];
    s1_cz_r <= SINE_TAB[az + ANGLE_W'(QUARTER)];

    p_sxsy_r  <= PROD_W'(sx)  * PROD_W'(sy);
    p_cxnsy_r <= PROD_W'(cx)  * PROD_W'(nsy);
    p_cxsy_r  <= PROD_W'(cx)  * PROD_W'(sy);
    p_cycz_r  <= PROD_W'(cy)  * PROD_W'(cz);
    p_cynsz_r <= PROD_W'(cy)  * PROD_W'(nsz);
    p_nsxcy_r <= PROD_W'(nsx) * PROD_W'(cy);
    p_cxsz_r  <= PROD_W'(cx)  * PROD_W'(sz);
    p_cxcz_r  <= PROD_W'(cx)  * PROD_W'(cz);
    p_sxsz_r  <= PROD_W'(sx)  * PROD_W'(sz);
    p_sxcz_r  <= PROD_W'(sx)  * PROD_W'(cz);
    p_cxcy_r  <= PROD_W'(cx)  * PROD_W'(cy);
    s2_sz_r   <= sz;
    s2_nsz_r  <= nsz;
    s2_cz_r   <= cz;
    s2_sy_r   <= s1_sy_r;

    q10_r     <= PROD2_W'(h_sxsy)  * PROD2_W'(s2_cz_r);
    q11_r     <= PROD2_W'(h_sxsy)  * PROD2_W'(s2_nsz_r);
    q20_r     <= PROD2_W'(h_cxnsy) * PROD2_W'(s2_cz_r);
    q21_r     <= PROD2_W'(h_cxsy)  * PROD2_W'(s2_sz_r);
    s3_cxsz_r <= p_cxsz_r;
    s3_cxcz_r <= p_cxcz_r;
    s3_sxsz_r <= p_sxsz_r;
    s3_sxcz_r <= p_sxcz_r;
    s3_m00_r  <= OUT_W'(p_cycz_r >>> FRACTION_BITS);
    s3_m01_r  <= OUT_W'(p_cynsz_r >>> FRACTION_BITS);
    s3_m02_r  <= OUT_W'(s2_sy_r);
    s3_m12_r  <= OUT_W'(p_nsxcy_r >>> FRACTION_BITS);
    s3_m22_r  <= OUT_W'(p_cxcy_r >>> FRACTION_BITS);

    out_r.m00 <= s3_m00_r;
    out_r.m01 <= s3_m01_r;
    out_r.m02 <= s3_m02_r;
    out_r.m10 <= OUT_W'(sum10 >>> FRACTION_BITS);
    out_r.m11 <= OUT_W'(sum11 >>> FRACTION_BITS);
    out_r.m12 <= s3_m12_r;
    out_r.m20 <= OUT_W'(sum20 >>> FRACTION_BITS);
    out_r.m21 <= OUT_W'(sum21 >>> FRACTION_BITS);
    out_r.m22 <= s3_m22_r;
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1 << FRACTION_BITS);

  a_valid_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without a transfer four cycles earlier");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(ax == '0 && ay == '0 && az == '0, 4)
    |-> out_data.m00 == ONE && out_data.m11 == ONE && out_data.m22 == ONE
        && out_data.m01 == '0 && out_data.m10 == '0 && out_data.m02 == '0)
    else $error("zero angles did not give the identity matrix");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

[sim/euler_rotation_matrix_tb.sv]
// Self-checking testbench for euler_rotation_matrix: directed and random angle triples.
`timescale 1ns / 1ps

module euler_rotation_matrix_tb;
  import erm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef logic [8:0][OUT_W-1:0] mat_flat_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  erm_in_t  in_data;
  logic     out_valid;
  erm_out_t out_data;

  int       sine_lut [SINE_ENTRIES];
  erm_out_t expected_mats [$];
  int       idle_pct;
  int       n_sent;
  int       n_checked;
  int       n_errors;
  int       quiet_cycles;
  string    entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  euler_rotation_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // rounded 2^F * sin(2*pi*i/N), folded onto the first quarter wave
  function automatic void fill_sine_lut();
    int  fold;
    int  j;
    int  q;
    real v;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      fold = i % HALF;
      j = (fold <= QUARTER) ? fold : HALF - fold;
      v = $sin(1.5707963267948966 * real'(j) / real'(QUARTER)) * real'(1 << FRACTION_BITS);
      q = $rtoi(v + 0.5);
      sine_lut[i] = (i < HALF) ? q : -q;
    end
  endfunction

  function automatic longint fshift(input longint v);
    return v >>> FRACTION_BITS;
  endfunction

  function automatic erm_out_t rotation_of(input erm_in_t a);
    erm_out_t r;
    longint   sx, sy, sz, cx, cy, cz;
    longint   sxsy, cxnsy, cxsy;
    sx = sine_lut[a.angle_x[ANGLE_W-1:0]];
    sy = sine_lut[a.angle_y[ANGLE_W-1:0]];
    sz = sine_lut[a.angle_z[ANGLE_W-1:0]];
    cx = sine_lut[(a.angle_x + QUARTER) % SINE_ENTRIES];
    cy = sine_lut[(a.angle_y + QUARTER) % SINE_ENTRIES];
    cz = sine_lut[(a.angle_z + QUARTER) % SINE_ENTRIES];
    sxsy  = fshift(sx * sy);
    cxnsy = fshift(cx * -sy);
    cxsy  = fshift(cx * sy);
    r.m00 = OUT_W'(fshift(cy * cz));
    r.m01 = OUT_W'(fshift(cy * -sz));
    r.m02 = OUT_W'(sy);
    r.m10 = OUT_W'(fshift(sxsy * cz + cx * sz));
    r.m11 = OUT_W'(fshift(sxsy * -sz + cx * cz));
    r.m12 = OUT_W'(fshift(-sx * cy));
    r.m20 = OUT_W'(fshift(cxnsy * cz + sx * sz));
    r.m21 = OUT_W'(fshift(cxsy * sz + sx * cz));
    r.m22 = OUT_W'(fshift(cx * cy));
    return r;
  endfunction

  task automatic send_angles(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                             input logic [IN_W-1:0] az);
    erm_in_t item;
    item.angle_x = ax;
    item.angle_y = ay;
    item.angle_z = az;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_mats.push_back(rotation_of(item));
    n_sent++;
  endtask

  function automatic logic [IN_W-1:0] random_angle();
    logic [IN_W-1:0] a;
    case ($urandom_range(3))
      0: begin
        a = IN_W'($urandom);
      end
      1: begin
        a = IN_W'($urandom_range(3) * QUARTER) + IN_W'($urandom_range(6)) - IN_W'(3);
        a[IN_W-1:ANGLE_W] = (IN_W-ANGLE_W)'($urandom);
      end
      default: begin
        a = IN_W'($urandom_range(SINE_ENTRIES - 1));
      end
    endcase
    return a;
  endfunction

  task automatic test_angle_extremes();
    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h0FFF, 16'h0000, 16'h0FFF);
    send_angles(16'h0400, 16'h0400, 16'h0400);
    send_angles(16'h0800, 16'h0800, 16'h0800);
    send_angles(16'h0C00, 16'h0C00, 16'h0C00);
    send_angles(16'h0200, 16'h0200, 16'h0200);
    send_angles(16'h0E00, 16'h0A00, 16'h0600);
    send_angles(16'h0600, 16'h0E00, 16'h0200);
  endtask

  // only the low angle bits count: the angle wraps modulo one turn
  task automatic test_high_bits_wrap();
    send_angles(16'hF000, 16'h1000, 16'h8000);
    send_angles(16'hF123, 16'h5123, 16'hA123);
    send_angles(16'h7400, 16'hAC00, 16'h5800);
    send_angles(16'hAAAA, 16'h5555, 16'hFFFF);
    send_angles(16'h5555, 16'hAAAA, 16'h0001);
  endtask

  // cosine index wraps past the end of the table
  task automatic test_cosine_wrap();
    send_angles(16'h0BFF, 16'h0C00, 16'h0C01);
    send_angles(16'h0FFE, 16'h0C01, 16'h0BFF);
    send_angles(16'h0C00, 16'h0FFF, 16'h0001);
    send_angles(16'h03FF, 16'h0401, 16'h0BFE);
    send_angles(16'h0001, 16'h07FF, 16'h0801);
  endtask

  task automatic test_random_angles(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_angles(random_angle(), random_angle(), random_angle());
  endtask

  always @(posedge clk) begin
    mat_flat_t got;
    mat_flat_t want;
    if (rst_n && out_valid) begin
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        n_errors++;
      end else begin
        got  = mat_flat_t'(out_data);
        want = mat_flat_t'(expected_mats.pop_front());
        for (int k = 0; k < 9; k++) begin
          if (got[8-k] !== want[8-k]) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, entry_name[k], want[8-k], got[8-k]);
            n_errors++;
          end
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_mats.size());
      $display("euler_rotation_matrix regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    idle_pct     = 9;
    n_sent       = 0;
    n_checked    = 0;
    n_errors     = 0;
    quiet_cycles = 0;
    fill_sine_lut();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_angle_extremes();
    test_high_bits_wrap();
    test_cosine_wrap();
    test_random_angles(615, 9);
    test_random_angles(615, 85);
    test_random_angles(620, 0);

    @(negedge clk);
    start <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_mats.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_mats.size());
      n_errors++;
    end

    $display("Covered %0d angle triples (extremes, high-bit and cosine wrap, random at three",
             n_sent);
    $display("sender idle rates); %0d matrices checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("euler_rotation_matrix regression: pass");
    end else begin
      $display("euler_rotation_matrix regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/erm_pkg.sv
rtl/euler_rotation_matrix.sv
sim/euler_rotation_matrix_tb.sv
